/* rtl/ptp_pkg.sv */
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared types, codes and saturation helpers of the point-to-point motion
// profiler.
// ----------------------------------------------------------------------------
package ptp_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // Thresholds in Q16.16.
  localparam logic [31:0] NEAR_DIST  = 32'd66;
  localparam logic [33:0] NEAR_SPEED = 34'd328;
  localparam logic [31:0] MIN_DIR    = 32'd16;

  // Datapath steps issued by the controller.
  typedef enum logic [5:0] {
    ST_NOP,
    ST_START,
    ST_STOP,
    ST_FIRST,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_SQRT_DIST,
    ST_TAKE_DIST,
    ST_CLEAR,
    ST_DIV_SIN,
    ST_TAKE_SIN,
    ST_DIV_COS,
    ST_TAKE_COS,
    ST_OLD_DIFF,
    ST_MUL_OX,
    ST_MUL_OY,
    ST_SQRT_OLD,
    ST_TAKE_OLD,
    ST_ZERO_OLD,
    ST_DIV_SO,
    ST_TAKE_SO,
    ST_DIV_CO,
    ST_TAKE_CO,
    ST_ROT1,
    ST_ROT2,
    ST_ROT3,
    ST_ROT4,
    ST_ROT5,
    ST_ROT6,
    ST_ROT7,
    ST_ROT8,
    ST_ROT9,
    ST_BRAKE,
    ST_DEC,
    ST_MUL_NN,
    ST_DIV_ARR,
    ST_TAKE_ARR,
    ST_DIV_VEL,
    ST_TAKE_VEL,
    ST_SQRT_N,
    ST_TAKE_ROOT,
    ST_DIV_CROSS,
    ST_TAKE_CROSS,
    ST_MOV1,
    ST_MOV2,
    ST_MOV3,
    ST_MOV4,
    ST_MOV5
  } step_e;

  typedef struct packed {
    logic  capture;
    logic  emit;
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       near;
    logic       d_long;
    logic       g_long;
    logic       retarget;
    logic       braking;
    logic       div_busy;
    logic       sqrt_busy;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Difference clamped symmetrically to +-(2^31-1).
  function automatic logic signed [31:0] clamp_diff(input logic signed [32:0] v);
    if (v > 33'sd2147483647) begin
      clamp_diff = 32'sh7fffffff;
    end else if (v < -33'sd2147483647) begin
      clamp_diff = 32'sh80000001;
    end else begin
      clamp_diff = v[31:0];
    end
  endfunction

  // Direction component clamped to +-1.0 in Q1.16.
  function automatic logic signed [17:0] unit_clamp(input logic signed [48:0] v);
    if (v > 49'sd65536) begin
      unit_clamp = 18'sd65536;
    end else if (v < -49'sd65536) begin
      unit_clamp = -18'sd65536;
    end else begin
      unit_clamp = v[17:0];
    end
  endfunction

endpackage

/* rtl/ptp_div.sv */
// ----------------------------------------------------------------------------
// ptp_div
// Signed by unsigned divider, truncating toward zero, two quotient bits a
// cycle over a 48-bit dividend magnitude.
// ----------------------------------------------------------------------------
module ptp_div import ptp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic signed [48:0] num_i,
  input  logic        [31:0] den_i,
  output logic               busy_o,
  output logic signed [48:0] quo_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic        neg_q;
  logic [31:0] den_q;
  logic [31:0] rem_q, rem_w;
  logic [47:0] quo_q, quo_w;
  logic [32:0] trial;
  logic [48:0] num_mag;

  assign num_mag = num_i[48] ? (49'd0 - num_i) : num_i;

  always_comb begin
    rem_w = rem_q;
    quo_w = quo_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_w, quo_w[47]};
      quo_w = {quo_w[46:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        quo_w[0] = 1'b1;
      end
      rem_w = trial[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd23;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      neg_q <= num_i[48];
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_mag[47:0];
    end else if (busy_q) begin
      rem_q <= rem_w;
      quo_q <= quo_w;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? (49'd0 - {1'b0, quo_q}) : {1'b0, quo_q};

endmodule

/* rtl/ptp_sqrt.sv */
// ----------------------------------------------------------------------------
// ptp_sqrt
// Integer square root of a 64-bit value, digit by digit, two root bits a
// cycle.
// ----------------------------------------------------------------------------
module ptp_sqrt import ptp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic [3:0]  cnt_q;
  logic [63:0] rad_q, rad_w;
  logic [32:0] rem_q, rem_w;
  logic [31:0] root_q, root_w;
  logic [34:0] part, trial;

  always_comb begin
    rad_w  = rad_q;
    rem_w  = rem_q;
    root_w = root_q;
    part   = '0;
    trial  = '0;
    for (int i = 0; i < 2; i++) begin
      part  = {rem_w, rad_w[63:62]};
      rad_w = {rad_w[61:0], 2'b00};
      trial = {1'b0, root_w, 2'b01};
      if (part >= trial) begin
        part   = part - trial;
        root_w = {root_w[30:0], 1'b1};
      end else begin
        root_w = {root_w[30:0], 1'b0};
      end
      rem_w = part[32:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 4'd15;
    end else if (busy_q) begin
      if (cnt_q == 4'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_w;
      rem_q  <= rem_w;
      root_q <= root_w;
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

/* rtl/ptp_dpath.sv */
// ----------------------------------------------------------------------------
// ptp_dpath
// Datapath of the motion profiler: motion state, one shared 32x32
// multiplier, the divider and the square-root unit, stepped by the
// controller.
// ----------------------------------------------------------------------------
module ptp_dpath import ptp_pkg::*; #(
  parameter int unsigned ARRIVAL_STEPS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            sts_o,
  input  logic        [1:0]  operation_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] load_x_i,
  input  logic signed [31:0] load_y_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic               moving_o,
  output logic               halted_o
);

  // Item and architectural state.
  logic        [1:0]  op_q;
  logic signed [31:0] tx_q, ty_q, lx_q, ly_q;
  logic signed [31:0] pos_x_q, pos_y_q, sa_q, sc_q, ltx_q, lty_q;
  logic signed [17:0] sin_q, cos_q;
  logic        [7:0]  steps_q;
  logic               braking_q, first_q, stop_q, moving_q;

  // Working registers.
  logic signed [31:0] dx_q, dy_q, ox_q, oy_q, ntx_q, nty_q;
  logic        [31:0] d_q, g_q;
  logic signed [17:0] so_q, co_q;
  logic signed [63:0] acc_q, prod_q;
  logic        [20:0] sqv_q;

  // Result register.
  logic signed [31:0] out_x_q, out_y_q;
  logic               out_moving_q, out_halted_q;

  logic signed [31:0] mul_a, mul_b;
  logic               div_go, sqrt_go, div_busy, sqrt_busy;
  logic signed [48:0] div_num, div_quo;
  logic        [31:0] div_den, sqrt_root;
  logic        [63:0] sqrt_rad;

  logic        [7:0]  n;
  logic signed [47:0] mq;
  logic signed [63:0] mq64, q64, sa64, sc64, px64, py64;
  logic signed [63:0] acc_minus_mq, acc_plus_mq, pos_x_sum, pos_y_sum;
  logic signed [63:0] arr_sum, vel_sum, cross_sum;
  logic signed [31:0] sin32, cos32, so32, co32;
  logic signed [32:0] ndy33;
  logic        [35:0] d12;
  logic signed [34:0] sa35, va6;
  logic        [32:0] amag, cmag;
  logic        [33:0] speed_sum;

  assign n     = (steps_q == 8'd0) ? 8'd1 : steps_q;
  assign mq    = prod_q[63:16];
  assign mq64  = {{16{mq[47]}}, mq};
  assign q64   = {{15{div_quo[48]}}, div_quo};
  assign sa64  = {{32{sa_q[31]}}, sa_q};
  assign sc64  = {{32{sc_q[31]}}, sc_q};
  assign px64  = {{32{pos_x_q[31]}}, pos_x_q};
  assign py64  = {{32{pos_y_q[31]}}, pos_y_q};
  assign sin32 = {{14{sin_q[17]}}, sin_q};
  assign cos32 = {{14{cos_q[17]}}, cos_q};
  assign so32  = {{14{so_q[17]}}, so_q};
  assign co32  = {{14{co_q[17]}}, co_q};

  assign acc_minus_mq = acc_q - mq64;
  assign acc_plus_mq  = acc_q + mq64;
  assign pos_x_sum    = px64 + acc_q + mq64;
  assign pos_y_sum    = py64 + acc_q + mq64;
  assign arr_sum      = sa64 + q64;
  assign vel_sum      = acc_q - q64;
  assign cross_sum    = sc64 - q64;

  assign ndy33 = 33'd0 - {dy_q[31], dy_q};
  assign d12   = ({4'd0, d_q} << 3) + ({4'd0, d_q} << 2);
  assign sa35  = {{3{sa_q[31]}}, sa_q};
  assign va6   = (sa35 << 2) + (sa35 << 1);

  assign amag      = sa_q[31] ? (33'd0 - {sa_q[31], sa_q}) : {1'b0, sa_q};
  assign cmag      = sc_q[31] ? (33'd0 - {sc_q[31], sc_q}) : {1'b0, sc_q};
  assign speed_sum = {1'b0, amag} + {1'b0, cmag};

  assign sts_o.op        = op_q;
  assign sts_o.near      = (d_q < NEAR_DIST) && (speed_sum < NEAR_SPEED);
  assign sts_o.d_long    = d_q > MIN_DIR;
  assign sts_o.g_long    = g_q > MIN_DIR;
  assign sts_o.retarget  = ((tx_q != ltx_q) || (ty_q != lty_q)) && !stop_q;
  assign sts_o.braking   = braking_q;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.sqrt_busy = sqrt_busy;

  // Multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      ST_MUL_DX: begin mul_a = dx_q;  mul_b = dx_q;  end
      ST_MUL_DY: begin mul_a = dy_q;  mul_b = dy_q;  end
      ST_MUL_OX: begin mul_a = ox_q;  mul_b = ox_q;  end
      ST_MUL_OY: begin mul_a = oy_q;  mul_b = oy_q;  end
      ST_MUL_NN: begin mul_a = {24'd0, n}; mul_b = {24'd0, n}; end
      ST_ROT1:   begin mul_a = sa_q;  mul_b = co32;  end
      ST_ROT2:   begin mul_a = sc_q;  mul_b = so32;  end
      ST_ROT3:   begin mul_a = sa_q;  mul_b = so32;  end
      ST_ROT4:   begin mul_a = sc_q;  mul_b = co32;  end
      ST_ROT5:   begin mul_a = ntx_q; mul_b = cos32; end
      ST_ROT6:   begin mul_a = nty_q; mul_b = sin32; end
      ST_ROT7:   begin mul_a = ntx_q; mul_b = sin32; end
      ST_ROT8:   begin mul_a = nty_q; mul_b = cos32; end
      ST_MOV1:   begin mul_a = sa_q;  mul_b = cos32; end
      ST_MOV2:   begin mul_a = sc_q;  mul_b = sin32; end
      ST_MOV3:   begin mul_a = sa_q;  mul_b = sin32; end
      ST_MOV4:   begin mul_a = sc_q;  mul_b = cos32; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider and square-root launches.
  always_comb begin
    div_go   = 1'b0;
    div_num  = '0;
    div_den  = '0;
    sqrt_go  = 1'b0;
    sqrt_rad = '0;
    case (cmd_i.step)
      ST_SQRT_DIST: begin sqrt_go = 1'b1; sqrt_rad = acc_q + prod_q; end
      ST_SQRT_OLD:  begin sqrt_go = 1'b1; sqrt_rad = acc_q + prod_q; end
      ST_SQRT_N:    begin sqrt_go = 1'b1; sqrt_rad = {24'd0, n, 32'd0}; end
      ST_DIV_SIN: begin
        div_go = 1'b1; div_num = {ndy33, 16'd0}; div_den = d_q;
      end
      ST_DIV_COS: begin
        div_go = 1'b1; div_num = {dx_q[31], dx_q, 16'd0}; div_den = d_q;
      end
      ST_DIV_SO: begin
        div_go = 1'b1; div_num = {oy_q[31], oy_q, 16'd0}; div_den = g_q;
      end
      ST_DIV_CO: begin
        div_go = 1'b1; div_num = {ox_q[31], ox_q, 16'd0}; div_den = g_q;
      end
      ST_DIV_ARR: begin
        div_go = 1'b1; div_num = {13'd0, d12}; div_den = {16'd0, prod_q[15:0]};
      end
      ST_DIV_VEL: begin
        div_go = 1'b1; div_num = {{14{va6[34]}}, va6}; div_den = {24'd0, n};
      end
      ST_DIV_CROSS: begin
        div_go = 1'b1; div_num = {sc_q[31], sc_q, 16'd0}; div_den = {11'd0, sqv_q};
      end
      default: begin
        div_go  = 1'b0;
        sqrt_go = 1'b0;
      end
    endcase
  end

  ptp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  ptp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (sqrt_go),
    .rad_i  (sqrt_rad),
    .busy_o (sqrt_busy),
    .root_o (sqrt_root)
  );

  // Architectural motion state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      sa_q      <= '0;
      sc_q      <= '0;
      ltx_q     <= '0;
      lty_q     <= '0;
      sin_q     <= '0;
      cos_q     <= 18'sd65536;
      steps_q   <= '0;
      braking_q <= 1'b1;
      first_q   <= 1'b1;
      stop_q    <= 1'b0;
    end else begin
      case (cmd_i.step)
        ST_START: begin
          pos_x_q <= lx_q;
          pos_y_q <= ly_q;
          first_q <= 1'b1;
          ltx_q   <= '0;
          lty_q   <= '0;
          sa_q    <= '0;
          sc_q    <= '0;
          stop_q  <= 1'b0;
        end
        ST_STOP: stop_q <= 1'b1;
        ST_FIRST: begin
          if (first_q) begin
            ltx_q   <= pos_x_q;
            lty_q   <= pos_y_q;
            first_q <= 1'b0;
          end
        end
        ST_CLEAR: begin
          sa_q <= '0;
          sc_q <= '0;
        end
        ST_TAKE_SIN: sin_q <= unit_clamp(div_quo);
        ST_TAKE_COS: cos_q <= unit_clamp(div_quo);
        ST_OLD_DIFF: begin
          steps_q   <= 8'(ARRIVAL_STEPS);
          braking_q <= 1'b0;
        end
        ST_ROT7: sa_q <= sat32(acc_minus_mq);
        ST_ROT9: begin
          sc_q  <= sat32(acc_plus_mq);
          ltx_q <= tx_q;
          lty_q <= ty_q;
        end
        ST_BRAKE: sa_q <= '0;
        ST_DEC: begin
          if (steps_q != 8'd0) begin
            steps_q <= steps_q - 8'd1;
          end
        end
        ST_TAKE_VEL: sa_q <= sat32(vel_sum);
        ST_TAKE_CROSS: begin
          sc_q <= sat32(cross_sum);
          if (steps_q == 8'd1) begin
            braking_q <= 1'b1;
          end
        end
        ST_MOV3: pos_x_q <= sat32(pos_x_sum);
        ST_MOV5: pos_y_q <= sat32(pos_y_sum);
        default: begin
          stop_q <= stop_q;
        end
      endcase
    end
  end

  // Working registers, item capture and the result register.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      tx_q     <= target_x_i;
      ty_q     <= target_y_i;
      lx_q     <= load_x_i;
      ly_q     <= load_y_i;
      moving_q <= 1'b0;
    end
    if (cmd_i.emit) begin
      out_x_q      <= pos_x_q;
      out_y_q      <= pos_y_q;
      out_moving_q <= moving_q;
      out_halted_q <= stop_q && (sa_q == 32'sd0) && (sc_q == 32'sd0);
    end
    case (cmd_i.step)
      ST_FIRST: begin
        dx_q <= clamp_diff({tx_q[31], tx_q} - {pos_x_q[31], pos_x_q});
        dy_q <= clamp_diff({ty_q[31], ty_q} - {pos_y_q[31], pos_y_q});
      end
      ST_MUL_DY:    acc_q <= prod_q;
      ST_TAKE_DIST: d_q   <= sqrt_root;
      ST_OLD_DIFF: begin
        ox_q <= clamp_diff({ltx_q[31], ltx_q} - {pos_x_q[31], pos_x_q});
        oy_q <= clamp_diff({lty_q[31], lty_q} - {pos_y_q[31], pos_y_q});
      end
      ST_MUL_OY:    acc_q <= prod_q;
      ST_TAKE_OLD:  g_q   <= sqrt_root;
      ST_ZERO_OLD: begin
        so_q <= '0;
        co_q <= '0;
      end
      ST_TAKE_SO:   so_q  <= unit_clamp(div_quo);
      ST_TAKE_CO:   co_q  <= unit_clamp(div_quo);
      ST_ROT2:      acc_q <= mq64;
      ST_ROT3:      ntx_q <= sat32(acc_minus_mq);
      ST_ROT4:      acc_q <= mq64;
      ST_ROT5:      nty_q <= sat32(acc_plus_mq);
      ST_ROT6:      acc_q <= mq64;
      ST_ROT8:      acc_q <= mq64;
      ST_TAKE_ARR:  acc_q <= arr_sum;
      ST_TAKE_ROOT: sqv_q <= sqrt_root[20:0];
      ST_MOV2:      acc_q <= mq64;
      ST_MOV4:      acc_q <= 64'sd0 - mq64;
      ST_MOV5:      moving_q <= 1'b1;
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign pos_x_o  = out_x_q;
  assign pos_y_o  = out_y_q;
  assign moving_o = out_moving_q;
  assign halted_o = out_halted_q;

endmodule

/* rtl/ptp_ctrl.sv */
// ----------------------------------------------------------------------------
// ptp_ctrl
// Controller of the motion profiler: sequences the datapath steps of one
// item and owns both handshakes.
// ----------------------------------------------------------------------------
module ptp_ctrl import ptp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_DECODE  = 6'd1;
  localparam logic [5:0] S_FIRST   = 6'd2;
  localparam logic [5:0] S_SQX     = 6'd3;
  localparam logic [5:0] S_SQY     = 6'd4;
  localparam logic [5:0] S_DGO     = 6'd5;
  localparam logic [5:0] S_DWAIT   = 6'd6;
  localparam logic [5:0] S_NEAR    = 6'd7;
  localparam logic [5:0] S_CLEAR   = 6'd8;
  localparam logic [5:0] S_SINGO   = 6'd9;
  localparam logic [5:0] S_SINWAIT = 6'd10;
  localparam logic [5:0] S_COSGO   = 6'd11;
  localparam logic [5:0] S_COSWAIT = 6'd12;
  localparam logic [5:0] S_RETGT   = 6'd13;
  localparam logic [5:0] S_OLD     = 6'd14;
  localparam logic [5:0] S_OSQX    = 6'd15;
  localparam logic [5:0] S_OSQY    = 6'd16;
  localparam logic [5:0] S_GGO     = 6'd17;
  localparam logic [5:0] S_GWAIT   = 6'd18;
  localparam logic [5:0] S_GCHK    = 6'd19;
  localparam logic [5:0] S_ZOLD    = 6'd20;
  localparam logic [5:0] S_SOGO    = 6'd21;
  localparam logic [5:0] S_SOWAIT  = 6'd22;
  localparam logic [5:0] S_COGO    = 6'd23;
  localparam logic [5:0] S_COWAIT  = 6'd24;
  localparam logic [5:0] S_ROT1    = 6'd25;
  localparam logic [5:0] S_ROT2    = 6'd26;
  localparam logic [5:0] S_ROT3    = 6'd27;
  localparam logic [5:0] S_ROT4    = 6'd28;
  localparam logic [5:0] S_ROT5    = 6'd29;
  localparam logic [5:0] S_ROT6    = 6'd30;
  localparam logic [5:0] S_ROT7    = 6'd31;
  localparam logic [5:0] S_ROT8    = 6'd32;
  localparam logic [5:0] S_ROT9    = 6'd33;
  localparam logic [5:0] S_BRAKE   = 6'd34;
  localparam logic [5:0] S_DEC     = 6'd35;
  localparam logic [5:0] S_NN      = 6'd36;
  localparam logic [5:0] S_AGO     = 6'd37;
  localparam logic [5:0] S_AWAIT   = 6'd38;
  localparam logic [5:0] S_VGO     = 6'd39;
  localparam logic [5:0] S_VWAIT   = 6'd40;
  localparam logic [5:0] S_RGO     = 6'd41;
  localparam logic [5:0] S_RWAIT   = 6'd42;
  localparam logic [5:0] S_CGO     = 6'd43;
  localparam logic [5:0] S_CWAIT   = 6'd44;
  localparam logic [5:0] S_MOV1    = 6'd45;
  localparam logic [5:0] S_MOV2    = 6'd46;
  localparam logic [5:0] S_MOV3    = 6'd47;
  localparam logic [5:0] S_MOV4    = 6'd48;
  localparam logic [5:0] S_MOV5    = 6'd49;
  localparam logic [5:0] S_DONE    = 6'd50;

  logic [5:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.emit    = 1'b0;
    cmd_o.step    = ST_NOP;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.op == OP_TICK) begin
          state_d = S_FIRST;
        end else begin
          state_d = S_DONE;
          if (sts_i.op == OP_START) begin
            cmd_o.step = ST_START;
          end else if (sts_i.op == OP_STOP) begin
            cmd_o.step = ST_STOP;
          end
        end
      end
      S_FIRST: begin cmd_o.step = ST_FIRST;     state_d = S_SQX;   end
      S_SQX:   begin cmd_o.step = ST_MUL_DX;    state_d = S_SQY;   end
      S_SQY:   begin cmd_o.step = ST_MUL_DY;    state_d = S_DGO;   end
      S_DGO:   begin cmd_o.step = ST_SQRT_DIST; state_d = S_DWAIT; end
      S_DWAIT: begin
        if (!sts_i.sqrt_busy) begin
          cmd_o.step = ST_TAKE_DIST;
          state_d    = S_NEAR;
        end
      end
      S_NEAR: begin
        if (sts_i.near) begin
          state_d = S_CLEAR;
        end else if (sts_i.d_long) begin
          state_d = S_SINGO;
        end else begin
          state_d = S_RETGT;
        end
      end
      S_CLEAR: begin cmd_o.step = ST_CLEAR;   state_d = S_DONE;    end
      S_SINGO: begin cmd_o.step = ST_DIV_SIN; state_d = S_SINWAIT; end
      S_SINWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.step = ST_TAKE_SIN;
          state_d    = S_COSGO;
        end
      end
      S_COSGO: begin cmd_o.step = ST_DIV_COS; state_d = S_COSWAIT; end
      S_COSWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.step = ST_TAKE_COS;
          state_d    = S_RETGT;
        end
      end
      S_RETGT: begin
        if (sts_i.retarget) begin
          state_d = S_OLD;
        end else if (sts_i.braking) begin
          state_d = S_BRAKE;
        end else begin
          state_d = S_DEC;
        end
      end
      S_OLD:  begin cmd_o.step = ST_OLD_DIFF; state_d = S_OSQX;  end
      S_OSQX: begin cmd_o.step = ST_MUL_OX;   state_d = S_OSQY;  end
      S_OSQY: begin cmd_o.step = ST_MUL_OY;   state_d = S_GGO;   end
      S_GGO:  begin cmd_o.step = ST_SQRT_OLD; state_d = S_GWAIT; end
      S_GWAIT: begin
        if (!sts_i.sqrt_busy) begin
          cmd_o.step = ST_TAKE_OLD;
          state_d    = S_GCHK;
        end
      end
      S_GCHK: state_d = sts_i.g_long ? S_SOGO : S_ZOLD;
      S_ZOLD: begin cmd_o.step = ST_ZERO_OLD; state_d = S_ROT1;   end
      S_SOGO: begin cmd_o.step = ST_DIV_SO;   state_d = S_SOWAIT; end
      S_SOWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.step = ST_TAKE_SO;
          state_d    = S_COGO;
        end
      end
      S_COGO: begin cmd_o.step = ST_DIV_CO; state_d = S_COWAIT; end
      S_COWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.step = ST_TAKE_CO;
          state_d    = S_ROT1;
        end
      end
      S_ROT1: begin cmd_o.step = ST_ROT1; state_d = S_ROT2; end
      S_ROT2: begin cmd_o.step = ST_ROT2; state_d = S_ROT3; end
      S_ROT3: begin cmd_o.step = ST_ROT3; state_d = S_ROT4; end
      S_ROT4: begin cmd_o.step = ST_ROT4; state_d = S_ROT5; end
      S_ROT5: begin cmd_o.step = ST_ROT5; state_d = S_ROT6; end
      S_ROT6: begin cmd_o.step = ST_ROT6; state_d = S_ROT7; end
      S_ROT7: begin cmd_o.step = ST_ROT7; state_d = S_ROT8; end
      S_ROT8: begin cmd_o.step = ST_ROT8; state_d = S_ROT9; end
      // A retarget (a new target while not stopped and not near) clears the braking phase, so the arrival law runs.
      S_ROT9:  begin cmd_o.step = ST_ROT9;    state_d = S_DEC;   end
      S_BRAKE: begin cmd_o.step = ST_BRAKE;   state_d = S_MOV1;  end
      S_DEC:   begin cmd_o.step = ST_DEC;     state_d = S_NN;    end
      S_NN:    begin cmd_o.step = ST_MUL_NN;  state_d = S_AGO;   end
      S_AGO:   begin cmd_o.step = ST_DIV_ARR; state_d = S_AWAIT; end
      S_AWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.step = ST_TAKE_ARR;
          state_d    = S_VGO;
        end
      end
      S_VGO: begin cmd_o.step = ST_DIV_VEL; state_d = S_VWAIT; end
      S_VWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.step = ST_TAKE_VEL;
          state_d    = S_RGO;
        end
      end
      S_RGO: begin cmd_o.step = ST_SQRT_N; state_d = S_RWAIT; end
      S_RWAIT: begin
        if (!sts_i.sqrt_busy) begin
          cmd_o.step = ST_TAKE_ROOT;
          state_d    = S_CGO;
        end
      end
      S_CGO: begin cmd_o.step = ST_DIV_CROSS; state_d = S_CWAIT; end
      S_CWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.step = ST_TAKE_CROSS;
          state_d    = S_MOV1;
        end
      end
      S_MOV1: begin cmd_o.step = ST_MOV1; state_d = S_MOV2; end
      S_MOV2: begin cmd_o.step = ST_MOV2; state_d = S_MOV3; end
      S_MOV3: begin cmd_o.step = ST_MOV3; state_d = S_MOV4; end
      S_MOV4: begin cmd_o.step = ST_MOV4; state_d = S_MOV5; end
      S_MOV5: begin cmd_o.step = ST_MOV5; state_d = S_DONE; end
      S_DONE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/point_to_point_motion_profiler_top.sv */
// ----------------------------------------------------------------------------
// point_to_point_motion_profiler_top
// Moves a 2-D point toward a target one tick item at a time, in Q16.16.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | operation, target_x/y, load_x/y
//   out     | output    | out_valid_o / out_stall_i | pos_x/y, moving, halted
//
// A tick is shortest with the point already at rest and longest with a new
// target and the full arrival law; its length is set by the shared divider
// and the shared square-root unit, used one after another.
// One item is in work at a time; the next is taken once the result has been
// moved to the output register, which holds it while out_stall_i is high.
// Reset is asynchronous and active low and needs no clearing pass.
// ----------------------------------------------------------------------------
module point_to_point_motion_profiler_top import ptp_pkg::*; #(
  parameter int unsigned ARRIVAL_STEPS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [1:0]  operation_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] load_x_i,
  input  logic signed [31:0] load_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic               moving_o,
  output logic               halted_o
);

  cmd_t    cmd;
  status_t sts;

  ptp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptp_dpath #(
    .ARRIVAL_STEPS (ARRIVAL_STEPS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .target_x_i  (target_x_i),
    .target_y_i  (target_y_i),
    .load_x_i    (load_x_i),
    .load_y_i    (load_y_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .moving_o    (moving_o),
    .halted_o    (halted_o)
  );

endmodule

/* dv/tb_point_to_point_motion_profiler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_to_point_motion_profiler_top
// Drives start, stop, tick and unused-code items into the motion profiler,
// predicts each position and status result in Q16.16 and checks every result
// field by field, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_point_to_point_motion_profiler_top;
  import ptp_pkg::*;

  localparam int unsigned STEPS      = 32;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          ITEM_GOAL  = 1550;
  localparam int          CALM_TAIL  = 150;
  localparam longint      CYCLE_CAP  = 3000000;
  localparam int          SETTLE     = 400;
  localparam longint      ONE_Q      = 65536;
  localparam longint      WORD_MAX   = 64'sd2147483647;
  localparam longint      WORD_MIN   = -64'sd2147483648;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    bit                 drain;
  } motion_item_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               moving;
    logic               halted;
  } motion_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic        [1:0]  operation_i;
  logic signed [31:0] target_x_i;
  logic signed [31:0] target_y_i;
  logic signed [31:0] load_x_i;
  logic signed [31:0] load_y_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic               moving_o;
  logic               halted_o;

  point_to_point_motion_profiler_top #(.ARRIVAL_STEPS(STEPS)) dut (.*);

  motion_item_t   pending_items[$];
  motion_result_t expected_results[$];
  int             failures;
  bit             stimulus_done;
  bit             calm;
  longint         cycles;

  // Predicted profiler state.
  longint at_x, at_y, vel_par, vel_perp, goal_x, goal_y, sin_q, cos_q;
  int     countdown;
  bit     coasting, fresh, stop_flag;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_word(input longint v);
    return clip(v, WORD_MIN, WORD_MAX);
  endfunction

  function automatic longint root_floor(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint span(input longint dx, input longint dy);
    return root_floor(longint'(dx * dx) + longint'(dy * dy));
  endfunction

  function automatic longint unit_of(input longint comp, input longint len);
    return clip((comp * ONE_Q) / len, -ONE_Q, ONE_Q);
  endfunction

  // Q16.16 by Q1.16 with floor rounding; >>> on a signed longint floors.
  function automatic longint mul_q(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic bit step_toward(input longint tx, input longint ty);
    longint dx, dy, d, n, va, vc, ox, oy, g, so, co, ntx, nty, rx, ry;
    if (fresh) begin
      goal_x = at_x;
      goal_y = at_y;
      fresh = 0;
    end
    dx = clip(tx - at_x, -WORD_MAX, WORD_MAX);
    dy = clip(ty - at_y, -WORD_MAX, WORD_MAX);
    d = span(dx, dy);
    if (d < 66 && ((vel_par < 0 ? -vel_par : vel_par) +
                   (vel_perp < 0 ? -vel_perp : vel_perp)) < 328) begin
      vel_par = 0;
      vel_perp = 0;
      return 0;
    end
    if (d > 16) begin
      sin_q = unit_of(-dy, d);
      cos_q = unit_of(dx, d);
    end
    if ((tx != goal_x || ty != goal_y) && !stop_flag) begin
      countdown = STEPS;
      coasting = 0;
      ox = clip(goal_x - at_x, -WORD_MAX, WORD_MAX);
      oy = clip(goal_y - at_y, -WORD_MAX, WORD_MAX);
      g = span(ox, oy);
      so = 0;
      co = 0;
      if (g > 16) begin
        so = unit_of(oy, g);
        co = unit_of(ox, g);
      end
      ntx = sat_word(mul_q(vel_par, co) - mul_q(vel_perp, so));
      nty = sat_word(mul_q(vel_par, so) + mul_q(vel_perp, co));
      vel_par = sat_word(mul_q(ntx, cos_q) - mul_q(nty, sin_q));
      vel_perp = sat_word(mul_q(ntx, sin_q) + mul_q(nty, cos_q));
      goal_x = tx;
      goal_y = ty;
    end
    if (!coasting) begin
      if (countdown > 0) countdown--;
      n = countdown < 1 ? 1 : countdown;
      va = vel_par;
      vel_par = sat_word(va + (12 * d) / (n * n) - (6 * va) / n);
      vc = vel_perp;
      vel_perp = sat_word(vc - (vc * ONE_Q) / root_floor(longint'(n) << 32));
      if (countdown == 1) coasting = 1;
    end else begin
      vel_par = 0;
    end
    rx = mul_q(vel_par, cos_q) + mul_q(vel_perp, sin_q);
    ry = -mul_q(vel_par, sin_q) + mul_q(vel_perp, cos_q);
    at_x = sat_word(at_x + rx);
    at_y = sat_word(at_y + ry);
    return 1;
  endfunction

  function automatic motion_result_t predict_position(input motion_item_t it);
    motion_result_t r;
    bit moved;
    moved = 0;
    case (it.op)
      OP_TICK: begin
        moved = step_toward(longint'(it.tx), longint'(it.ty));
      end
      OP_START: begin
        at_x = it.lx;
        at_y = it.ly;
        fresh = 1;
        goal_x = 0;
        goal_y = 0;
        vel_par = 0;
        vel_perp = 0;
        stop_flag = 0;
      end
      OP_STOP: begin
        stop_flag = 1;
      end
      default: begin
      end
    endcase
    r.px = at_x[31:0];
    r.py = at_y[31:0];
    r.moving = moved;
    r.halted = stop_flag && vel_par == 0 && vel_perp == 0;
    return r;
  endfunction

  // Mostly modest coordinates, with some full-range values and extremes.
  function automatic logic signed [31:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
    if (sel < 8) return $urandom;
    if (sel == 8) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    return $signed($urandom_range(0, 255)) - 128;
  endfunction

  task automatic add_item(input logic [1:0] op, input logic signed [31:0] tx,
                          input logic signed [31:0] ty, input logic signed [31:0] lx,
                          input logic signed [31:0] ly, input bit drain = 0);
    motion_item_t it;
    it.op = op;
    it.tx = tx;
    it.ty = ty;
    it.lx = lx;
    it.ly = ly;
    it.drain = drain;
    pending_items.push_back(it);
  endtask

  task automatic add_tick(input logic signed [31:0] tx, input logic signed [31:0] ty);
    add_item(OP_TICK, tx, ty, $urandom, $urandom);
  endtask

  // Stimulus plan.
  initial begin
    int k, len;
    logic signed [31:0] gx, gy;
    // Ticks straight after reset, then extremes of position and target.
    add_tick(32'sd0, 32'sd0);
    add_tick(32'sh7fffffff, 32'sh80000000);
    add_tick(32'sh7fffffff, 32'sh80000000);
    add_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    add_item(OP_STOP, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    add_tick(32'sh80000000, 32'sh7fffffff);
    add_tick(32'sh80000000, 32'sh7fffffff);
    add_item(OP_START, 32'sd0, 32'sd0, 32'sh7fffffff, 32'sh7fffffff);
    add_tick(32'sh80000000, 32'sh80000000);
    add_tick(32'sh80000000, 32'sh80000000);
    add_item(OP_START, 32'sd0, 32'sd0, 32'sh80000000, 32'sh80000000);
    add_tick(32'sh80000000, 32'sh80000000);
    // Target within the distance threshold of the point at rest.
    add_item(OP_START, 32'sd0, 32'sd0, 32'sd1000, -32'sd1000);
    add_tick(32'sd1040, -32'sd1030);
    // Short direction: target a few LSBs away after motion has started.
    add_tick(32'sd1000000, 32'sd500000);
    add_tick(32'sd1000000, 32'sd500000);
    add_tick(32'sd1000005, 32'sd500003);
    add_tick(-32'sd700000, 32'sd900000);
    add_item(OP_STOP, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    add_tick(32'sd5, 32'sd5);
    add_tick(32'sd5, 32'sd5);
    add_item(OP_UNUSED, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1);
    add_tick(32'sd5, 32'sd5);

    while (pending_items.size() < ITEM_GOAL) begin
      if ($urandom_range(0, 99) < 85) begin
        add_item(OP_START, $urandom, $urandom, pick_coord(), pick_coord(),
                 pending_items.size() > 700 && pending_items.size() < 760
                 && $urandom_range(0, 9) == 0);
        gx = pick_coord();
        gy = pick_coord();
        len = $urandom_range(5, 45);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            gx = pick_coord();
            gy = pick_coord();
          end
          if ($urandom_range(0, 29) == 0)
            add_item(OP_STOP, $urandom, $urandom, $urandom, $urandom);
          else if ($urandom_range(0, 49) == 0)
            add_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
          else
            add_tick(gx, gy);
        end
      end else begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++)
          add_item(2'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                   pick_coord(), pick_coord());
      end
    end
  end

  // Driver.
  int gap_left;
  initial begin
    in_valid_i  = 1'b0;
    operation_i = OP_TICK;
    target_x_i  = '0;
    target_y_i  = '0;
    load_x_i    = '0;
    load_y_i    = '0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    motion_item_t it;
    if (!rst_ni) begin
      gap_left <= 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        it.op = operation_i;
        it.tx = target_x_i;
        it.ty = target_y_i;
        it.lx = load_x_i;
        it.ly = load_y_i;
        expected_results.push_back(predict_position(it));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid_i <= 1'b0;
        stimulus_done <= 1'b1;
      end else if (pending_items[0].drain && expected_results.size() != 0) begin
        in_valid_i <= 1'b0;
      end else begin
        it = pending_items.pop_front();
        operation_i <= it.op;
        target_x_i  <= it.tx;
        target_y_i  <= it.ty;
        load_x_i    <= it.lx;
        load_y_i    <= it.ly;
        in_valid_i  <= 1'b1;
        calm <= pending_items.size() < CALM_TAIL;
        if (pending_items.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
          gap_left <= $urandom_range(1, 11);
      end
    end
  end

  // Monitor and output stall.
  int stall_left;
  initial out_stall_i = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    motion_result_t want;
    if (!rst_ni) begin
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result pos=(%0d,%0d) moving=%0b halted=%0b",
                   $time, pos_x_o, pos_y_o, moving_o, halted_o);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (pos_x_o !== want.px || pos_y_o !== want.py ||
              moving_o !== want.moving || halted_o !== want.halted) begin
            $display("%0t: mismatch expected pos=(%0d,%0d) moving=%0b halted=%0b",
                     $time, want.px, want.py, want.moving, want.halted);
            $display("%0t:          actual   pos=(%0d,%0d) moving=%0b halted=%0b",
                     $time, pos_x_o, pos_y_o, moving_o, halted_o);
            failures++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    failures = 0;
    stimulus_done = 0;
    calm = 0;
    cycles = 0;
    at_x = 0;
    at_y = 0;
    vel_par = 0;
    vel_perp = 0;
    goal_x = 0;
    goal_y = 0;
    sin_q = 0;
    cos_q = ONE_Q;
    countdown = 0;
    coasting = 1;
    fresh = 1;
    stop_flag = 0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!stimulus_done || expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
